[design/sm4ks_pkg.sv]
// Package for the SM4 key-expansion round unit: item types, S-box and CK constants.
`default_nettype none
package sm4ks_pkg;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ROUND = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [1:0]  word_index;
      logic [31:0] word_value;
      logic [4:0]  round_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  slot;
      logic [31:0] key_word;
   } rsp_item_type;

   // Control from the top level to the ring: advance moves the held item through.
   typedef struct packed {
      logic         advance;
      req_item_type item;
   } ring_ctl_type;

   localparam logic [7:0] SBOX [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // CK[r]: byte j (j = 0 most significant) is (4r + j) * 7 mod 256.
   function automatic logic [31:0] ck_word(input logic [4:0] r);
      logic [31:0] v;
      logic [7:0]  base;
      v    = '0;
      base = {1'b0, r, 2'b00};
      for (int j = 0; j < 4; j++) begin
         v = {v[23:0], 8'((base + 8'(j)) * 8'd7)};
      end
      return v;
   endfunction

endpackage
`default_nettype wire

[design/sm4ks_tfunc.sv]
// Key-schedule transform T': byte-wise S-box followed by L'(x) = x ^ rol13 ^ rol23.
`default_nettype none
module sm4ks_tfunc (
   input  wire logic [31:0] x,
   output logic [31:0]      y
);
   import sm4ks_pkg::*;

   logic [31:0] tau;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         tau[8*b +: 8] = SBOX[x[8*b +: 8]];
      end
   end

   assign y = tau ^ {tau[18:0], tau[31:19]} ^ {tau[8:0], tau[31:9]};

endmodule
`default_nettype wire

[design/sm4ks_ring.sv]
// Four-word key ring: load and round update of one slot per advanced item.
`default_nettype none
module sm4ks_ring (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sm4ks_pkg::ring_ctl_type ctl,
   output sm4ks_pkg::rsp_item_type     result
);
   import sm4ks_pkg::*;

   logic [31:0] ring_ff [4];
   logic [31:0] ring_in [4];
   logic [1:0]  slot;
   logic [31:0] slot_word;
   logic [31:0] xor_all;
   logic [31:0] t_src;
   logic [31:0] t_out;
   logic [31:0] new_word;

   assign slot      = (ctl.item.kind == KIND_LOAD) ? ctl.item.word_index
                                                   : ctl.item.round_index[1:0];
   assign slot_word = ring_ff[slot];
   assign xor_all   = ring_ff[0] ^ ring_ff[1] ^ ring_ff[2] ^ ring_ff[3];
   // XOR of the three other words: remove the target slot from the full XOR.
   assign t_src     = xor_all ^ slot_word ^ ck_word(ctl.item.round_index);

   sm4ks_tfunc u_tfunc (
      .x (t_src),
      .y (t_out)
   );

   assign new_word = (ctl.item.kind == KIND_LOAD) ? ctl.item.word_value
                                                  : (slot_word ^ t_out);

   assign result.slot     = slot;
   assign result.key_word = new_word;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ring_in[i] = (ctl.advance && (slot == 2'(i))) ? new_word : ring_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (reset) begin
            ring_ff[i] <= '0;
         end else begin
            ring_ff[i] <= ring_in[i];
         end
      end
   end

endmodule
`default_nettype wire

[design/sm4_key_schedule_round.sv]
// Top level of the SM4 key-expansion round unit: input register, ring, result register.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   req      | in        | req_valid/req_ready  | kind, word_index, word_value, round_index
//   rsp      | out       | rsp_valid/rsp_ready  | slot, key_word
//
// An item goes from the input register to the result register once the result register
// is free: the S-box and L' logic sits between the input register and the result
// register, so the whole round is done while the item is held in the input register.
// One item is taken per cycle while rsp is not stalled; the ring is updated as an item
// leaves the input register, so the next item already sees the new word.
// Reset clears the ring to zeros and empties both registers.
// A stalled rsp holds the result; the input register still drains into it once
// it frees, and req_ready drops only when both registers are full and stalled.
`default_nettype none
module sm4_key_schedule_round (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire sm4ks_pkg::req_item_type req_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output sm4ks_pkg::rsp_item_type      rsp_item
);
   import sm4ks_pkg::*;

   req_item_type item_ff;
   logic         item_valid_ff;
   logic         item_valid_in;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         advance;
   logic         req_xfer;
   ring_ctl_type ring_ctl;
   rsp_item_type ring_result;

   // Advance the held item when the result register is empty or being drained.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign ring_ctl.advance = advance;
   assign ring_ctl.item    = item_ff;

   sm4ks_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ring_ctl),
      .result (ring_result)
   );

   assign item_valid_in = req_xfer || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: capture on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= ring_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A held item that cannot advance must stay held.
   a_item_kept : assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("held item dropped");

   // An advanced item always shows up as a result next cycle.
   a_adv_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item produced no result");

   // A load returns its own slot and word.
   a_load_echo : assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.kind == KIND_LOAD) |=>
         (rsp_item_ff.slot == $past(item_ff.word_index) &&
          rsp_item_ff.key_word == $past(item_ff.word_value)))
      else $error("load result mismatch");

   // A round writes slot round_index mod 4.
   a_round_slot : assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.kind == KIND_ROUND) |=>
         (rsp_item_ff.slot == $past(item_ff.round_index[1:0])))
      else $error("round slot mismatch");

endmodule
`default_nettype wire

[test/tb_sm4_key_schedule_round.sv]
// Testbench for the SM4 key-expansion round unit: table-driven and random items, scoreboarded.
module tb_sm4_key_schedule_round;
   timeunit 1ns;
   timeprecision 1ps;

   import sm4ks_pkg::*;

   // Give up after this many cycles.
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int ITEM_TARGET   = 1200;
   // Drop all idling on both sides once this many items have been sent.
   localparam int QUIET_FROM    = 1050;
   localparam int LONG_HOLD     = 80;
   localparam int DRAIN_CYCLES  = 8;
   localparam int NUM_DIRECTED  = 20;

   // SM4 S-box, entry 0 in the top byte.
   localparam logic [2047:0] SM4_SBOX_BYTES = {
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // One row of the directed table; 'typed' marks rows whose result is written out by hand.
   typedef struct packed {
      req_item_type item;
      logic         typed;
      rsp_item_type want;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;

   // Shadow copy of the key ring and the slot writes still owed by the block.
   logic [31:0]  ring_model [4];
   rsp_item_type ring_writes_due [$];

   dir_row_type  dir_rows [NUM_DIRECTED];
   int           error_count;
   int           items_sent;
   int           cycle_count;
   bit           quiet;
   bit           hold_rsp_long;

   sm4_key_schedule_round DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // CK[r]: byte j, most significant first, is (4r + j) * 7 mod 256.
   function automatic logic [31:0] round_constant(input logic [4:0] r);
      logic [31:0] v;
      logic [7:0]  b;
      v = '0;
      for (int j = 0; j < 4; j++) begin
         b = 8'(r) * 8'd4 + 8'(j);
         v = {v[23:0], 8'(b * 8'd7)};
      end
      return v;
   endfunction

   // Pass each byte of a word through the S-box.
   function automatic logic [31:0] sbox_word(input logic [31:0] x);
      logic [31:0] y;
      int          b;
      for (int k = 0; k < 4; k++) begin
         b = x[8*k +: 8];
         y[8*k +: 8] = SM4_SBOX_BYTES[2047 - 8*b -: 8];
      end
      return y;
   endfunction

   // Apply one item to the shadow ring; return the slot written and its new word.
   function automatic rsp_item_type next_ring_write(input req_item_type it);
      rsp_item_type res;
      logic [1:0]   s;
      logic [1:0]   s1;
      logic [1:0]   s2;
      logic [1:0]   s3;
      logic [31:0]  t;
      if (it.kind == KIND_LOAD) begin
         s = it.word_index;
         ring_model[s] = it.word_value;
      end else begin
         s  = it.round_index[1:0];
         s1 = s + 2'd1;
         s2 = s + 2'd2;
         s3 = s + 2'd3;
         t = ring_model[s1] ^ ring_model[s2] ^ ring_model[s3] ^ round_constant(it.round_index);
         t = sbox_word(t);
         t = t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
         ring_model[s] = ring_model[s] ^ t;
      end
      res.slot     = s;
      res.key_word = ring_model[s];
      return res;
   endfunction

   function automatic dir_row_type dir_row(input logic k, input logic [1:0] wi,
                                           input logic [31:0] wv, input logic [4:0] ri,
                                           input logic typed, input logic [1:0] want_slot,
                                           input logic [31:0] want_word);
      dir_row_type row;
      row.item.kind        = k;
      row.item.word_index  = wi;
      row.item.word_value  = wv;
      row.item.round_index = ri;
      row.typed            = typed;
      row.want.slot        = want_slot;
      row.want.key_word    = want_word;
      return row;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it.kind        = ($urandom_range(0, 1) == 0) ? KIND_LOAD : KIND_ROUND;
      it.word_index  = 2'($urandom_range(0, 3));
      it.word_value  = $urandom;
      it.round_index = 5'($urandom_range(0, 31));
      return it;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------------------

   // Offer one item and hold it until the transfer. Valid stays high on return so that a
   // following item goes out back to back; a random gap lowers it after the transfer.
   task automatic send_item(input req_item_type it, input logic typed, input rsp_item_type want);
      rsp_item_type predicted;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      // Advance the shadow ring on every transfer; a hand-typed result replaces the prediction.
      predicted = next_ring_write(it);
      ring_writes_due.push_back(typed ? want : predicted);
      items_sent++;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic send_random(input req_item_type it);
      send_item(it, 1'b0, '0);
   endtask

   // Drop valid and wait until every outstanding slot write has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (ring_writes_due.size() != 0);
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off on request, none in the quiet phase
   // ---------------------------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_long) begin
            // Hold off long enough for both internal registers to fill and stall req.
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp_long = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result check: compare each result transfer with the oldest expected slot write
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ring_writes_due.size() == 0) begin
            $display("%0t: unexpected result, actual slot %0d key_word %h",
                     $realtime, rsp_item.slot, rsp_item.key_word);
            error_count++;
         end else begin
            want = ring_writes_due.pop_front();
            if (rsp_item.slot !== want.slot) begin
               $display("%0t: slot mismatch, expected %0d actual %0d",
                        $realtime, want.slot, rsp_item.slot);
               error_count++;
            end
            if (rsp_item.key_word !== want.key_word) begin
               $display("%0t: key_word mismatch, expected %h actual %h",
                        $realtime, want.key_word, rsp_item.key_word);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding",
                  $realtime, ring_writes_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      req_item_type it;
      int           n_rounds;
      int           first_round;
      error_count   = 0;
      items_sent    = 0;
      cycle_count   = 0;
      quiet         = 1'b0;
      hold_rsp_long = 1'b0;
      for (int i = 0; i < 4; i++) ring_model[i] = '0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;

      // Rounds straight after reset, on an all-zero ring, with the unused load fields at
      // both extremes.
      dir_rows[0]  = dir_row(KIND_ROUND, 2'd0, 32'h0000_0000, 5'd0,  1'b0, 2'd0, 32'h0);
      dir_rows[1]  = dir_row(KIND_ROUND, 2'd3, 32'hffff_ffff, 5'd31, 1'b0, 2'd0, 32'h0);
      // Loads echo slot and word; round_index is ignored.
      dir_rows[2]  = dir_row(KIND_LOAD, 2'd0, 32'hffff_ffff, 5'd31, 1'b1, 2'd0, 32'hffff_ffff);
      dir_rows[3]  = dir_row(KIND_LOAD, 2'd3, 32'h0000_0000, 5'd31, 1'b1, 2'd3, 32'h0000_0000);
      dir_rows[4]  = dir_row(KIND_LOAD, 2'd1, 32'haaaa_aaaa, 5'd0,  1'b1, 2'd1, 32'haaaa_aaaa);
      dir_rows[5]  = dir_row(KIND_LOAD, 2'd2, 32'h5555_5555, 5'd21, 1'b1, 2'd2, 32'h5555_5555);
      dir_rows[6]  = dir_row(KIND_LOAD, 2'd3, 32'h8000_0001, 5'd10, 1'b1, 2'd3, 32'h8000_0001);
      // Rounds out of order on arbitrary ring contents, the slot wrapping with r.
      dir_rows[7]  = dir_row(KIND_ROUND, 2'd0, 32'h0000_0000, 5'd1,  1'b0, 2'd0, 32'h0);
      dir_rows[8]  = dir_row(KIND_ROUND, 2'd3, 32'hffff_ffff, 5'd2,  1'b0, 2'd0, 32'h0);
      dir_rows[9]  = dir_row(KIND_ROUND, 2'd1, 32'h1234_5678, 5'd3,  1'b0, 2'd0, 32'h0);
      dir_rows[10] = dir_row(KIND_ROUND, 2'd2, 32'h8765_4321, 5'd4,  1'b0, 2'd0, 32'h0);
      dir_rows[11] = dir_row(KIND_ROUND, 2'd0, 32'hffff_ffff, 5'd30, 1'b0, 2'd0, 32'h0);
      // Standard key 0123456789abcdeffedcba9876543210 with FK applied, then its first rounds.
      dir_rows[12] = dir_row(KIND_LOAD, 2'd0, 32'ha292_ffa1, 5'd0,  1'b1, 2'd0, 32'ha292_ffa1);
      dir_rows[13] = dir_row(KIND_LOAD, 2'd1, 32'hdf01_febf, 5'd0,  1'b1, 2'd1, 32'hdf01_febf);
      dir_rows[14] = dir_row(KIND_LOAD, 2'd2, 32'h99a1_2b0f, 5'd0,  1'b1, 2'd2, 32'h99a1_2b0f);
      dir_rows[15] = dir_row(KIND_LOAD, 2'd3, 32'hc424_10cc, 5'd0,  1'b1, 2'd3, 32'hc424_10cc);
      dir_rows[16] = dir_row(KIND_ROUND, 2'd0, 32'h0000_0000, 5'd0,  1'b0, 2'd0, 32'h0);
      dir_rows[17] = dir_row(KIND_ROUND, 2'd0, 32'h0000_0000, 5'd1,  1'b0, 2'd0, 32'h0);
      dir_rows[18] = dir_row(KIND_ROUND, 2'd0, 32'h0000_0000, 5'd2,  1'b0, 2'd0, 32'h0);
      dir_rows[19] = dir_row(KIND_ROUND, 2'd0, 32'h0000_0000, 5'd3,  1'b0, 2'd0, 32'h0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
      pause_until_drained();

      // Stall the result side for a long stretch while the next key schedule goes in.
      hold_rsp_long = 1'b1;

      while (items_sent < ITEM_TARGET) begin
         quiet = (items_sent >= QUIET_FROM);
         if ($urandom_range(0, 3) != 0) begin
            // Full key schedule: load all four slots, then run rounds in order. Break off
            // or start late now and then.
            for (int s = 0; s < 4; s++) begin
               it             = random_item();
               it.kind        = KIND_LOAD;
               it.word_index  = 2'(s);
               send_random(it);
            end
            n_rounds    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : 32;
            first_round = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : 0;
            for (int r = 0; r < n_rounds; r++) begin
               it             = random_item();
               it.kind        = KIND_ROUND;
               it.round_index = 5'(first_round + r);
               send_random(it);
            end
         end else begin
            // Noise: unconstrained items.
            repeat ($urandom_range(1, 8)) send_random(random_item());
         end
         if (!quiet && $urandom_range(0, 9) == 0) pause_until_drained();
      end

      // Hold valid low, wait for the last results, then give stray results time to show.
      req_valid <= 1'b0;
      do @(posedge clock); while (ring_writes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sm4_key_schedule_round.f]
design/sm4ks_pkg.sv
design/sm4ks_tfunc.sv
design/sm4ks_ring.sv
design/sm4_key_schedule_round.sv
test/tb_sm4_key_schedule_round.sv
